/* rtl/hrhp_pkg.sv */
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types and constants of the HTTP response header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  // Reset value of the header byte limit register
  localparam logic [15:0] LIMIT_RESET = 16'd16384;

  // Register indexes (word address bit above the byte lanes)
  localparam logic [0:0] REG_IDX_LIMIT = 1'b0;

  // Saturation limits of the parsed numbers
  localparam logic [15:0] STATUS_MAX = 16'hFFFF;
  localparam logic [30:0] LENGTH_MAX = 31'h7FFF_FFFF;

  // Columns at which each number scanner starts
  localparam int unsigned COL_CODE9  = 9;
  localparam int unsigned COL_CODE5  = 5;
  localparam int unsigned COL_LENGTH = 15;

  // Character codes
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_BODY   = 2'b10
  } phase_e;

  // Number scanner mode
  typedef enum logic [2:0] {
    SCAN_SKIP   = 3'b001,
    SCAN_DIGITS = 3'b010,
    SCAN_DONE   = 3'b100
  } scan_e;

  // One result word
  typedef struct packed {
    logic [15:0]        status_code;
    logic signed [31:0] body_length;
    logic               dead;
  } hrhp_result_t;

endpackage

`default_nettype wire

/* rtl/hrhp_in_if.sv */
// ----------------------------------------------------------------------------
// hrhp_in_if
// Input channel: one response byte or a stream-closed event per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/hrhp_out_if.sv */
// ----------------------------------------------------------------------------
// hrhp_out_if
// Result channel: status code, body length and dead flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhp_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        status_code;
  logic signed [31:0] body_length;
  logic               dead;

  modport source (output valid, output status_code, output body_length, output dead,
                  input ready);
  modport sink   (input valid, input status_code, input body_length, input dead,
                  output ready);
endinterface

`default_nettype wire

/* rtl/hrhp_parser.sv */
// ----------------------------------------------------------------------------
// hrhp_parser
// Per-byte header matcher, number scanners and body counter.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_parser import hrhp_pkg::*; #(
  parameter int unsigned LINE_BUF_BYTES = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         item_valid_i,
  input  wire logic         action_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic [15:0]  limit_i,
  output      logic         res_valid_o,
  output      hrhp_result_t res_o
);

  localparam int unsigned PW = $clog2(LINE_BUF_BYTES);
  localparam logic [PW-1:0] LINE_MAX = PW'(LINE_BUF_BYTES - 1);

  // Expected character of the version prefix
  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      3'd5:    c = "1";
      3'd6:    c = ".";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Expected lower-case character of the length header name
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Next scanner mode for one character
  function automatic scan_e scan_next(input scan_e m, input logic act, input logic dig,
                                      input logic blk);
    scan_e n;
    if (!act || m == SCAN_DONE || (m == SCAN_SKIP && blk)) begin
      n = m;
    end else if (!dig) begin
      n = SCAN_DONE;
    end else begin
      n = SCAN_DIGITS;
    end
    return n;
  endfunction

  // Multiply by ten, add a digit, saturate (16 bit)
  function automatic logic [15:0] acc16(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] n;
    n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {16'd0, d};
    return (n > {4'd0, STATUS_MAX}) ? STATUS_MAX : n[15:0];
  endfunction

  // Multiply by ten, add a digit, saturate (31 bit)
  function automatic logic [30:0] acc31(input logic [30:0] v, input logic [3:0] d);
    logic [34:0] n;
    n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {31'd0, d};
    return (n > {4'd0, LENGTH_MAX}) ? LENGTH_MAX : n[30:0];
  endfunction

  phase_e        phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          first_q, first_d;
  logic          ver_match_q, ver_match_d;
  logic          name_match_q, name_match_d;
  scan_e         mode9_q, mode9_d, mode5_q, mode5_d, model_q, model_d;
  logic [15:0]   code9_q, code9_d, code5_q, code5_d;
  logic [30:0]   cand_q, cand_d;
  logic [15:0]   status_q, status_d;
  logic          len_seen_q, len_seen_d;
  logic [30:0]   len_q, len_d;
  logic [16:0]   hdr_seen_q, hdr_seen_d;
  logic [30:0]   body_left_q, body_left_d;

  logic          feed;
  logic          is_digit, is_blank;
  logic [7:0]    lower;
  logic [3:0]    digit;
  logic          act9, act5, actl;
  logic [16:0]   hdr_inc;
  logic [30:0]   body_dec;
  logic          emit, emit_dead;
  logic [30:0]   emit_len;

  // Classify the incoming character
  assign is_digit = (data_byte_i >= "0") && (data_byte_i <= "9");
  assign is_blank = (data_byte_i == CHAR_SP) || (data_byte_i == CHAR_TAB);
  assign lower    = ((data_byte_i >= "A") && (data_byte_i <= "Z")) ? data_byte_i + 8'd32
                                                                   : data_byte_i;
  assign digit    = data_byte_i[3:0];
  assign act9     = feed && (pos_q >= PW'(COL_CODE9));
  assign act5     = feed && (pos_q >= PW'(COL_CODE5));
  assign actl     = feed && (pos_q >= PW'(COL_LENGTH));
  assign hdr_inc  = hdr_seen_q + 17'd1;
  assign body_dec = (body_left_q != 31'd0) ? body_left_q - 31'd1 : body_left_q;

  // Decide this byte's effect on the parser state
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    first_d      = first_q;
    ver_match_d  = ver_match_q;
    name_match_d = name_match_q;
    mode9_d      = mode9_q;
    mode5_d      = mode5_q;
    model_d      = model_q;
    code9_d      = code9_q;
    code5_d      = code5_q;
    cand_d       = cand_q;
    status_d     = status_q;
    len_seen_d   = len_seen_q;
    len_d        = len_q;
    hdr_seen_d   = hdr_seen_q;
    body_left_d  = body_left_q;
    feed         = 1'b0;
    emit         = 1'b0;
    emit_dead    = 1'b0;
    emit_len     = len_q;

    if (item_valid_i) begin
      if (action_i) begin
        emit      = 1'b1;
        emit_dead = 1'b1;
      end else if (phase_q == PH_BODY) begin
        body_left_d = body_dec;
        if (body_dec == 31'd0) begin
          emit = 1'b1;
        end
      end else begin
        if (hdr_inc > {1'b0, limit_i}) begin
          emit      = 1'b1;
          emit_dead = 1'b1;
        end else begin
          hdr_seen_d = hdr_inc;
          if (data_byte_i == CHAR_CR) begin
            // drop carriage returns
          end else if (data_byte_i != CHAR_LF) begin
            feed = (pos_q < LINE_MAX);
          end else if (pos_q == '0) begin
            // blank line closes the header section
            if (first_q || !len_seen_q) begin
              emit      = 1'b1;
              emit_dead = 1'b1;
            end else if (len_q == 31'd0) begin
              emit = 1'b1;
            end else begin
              phase_d     = PH_BODY;
              body_left_d = len_q;
            end
          end else begin
            // complete line: latch what it carried, then clear the line
            if (first_q) begin
              first_d = 1'b0;
              if (pos_q >= PW'(9) && ver_match_q) begin
                status_d = code9_q;
              end else if (pos_q >= PW'(6)) begin
                status_d = code5_q;
              end
            end else if (pos_q >= PW'(15) && name_match_q) begin
              len_d      = cand_q;
              len_seen_d = 1'b1;
            end
            pos_d        = '0;
            ver_match_d  = 1'b1;
            name_match_d = 1'b1;
            mode9_d      = SCAN_SKIP;
            mode5_d      = SCAN_SKIP;
            model_d      = SCAN_SKIP;
            code9_d      = '0;
            code5_d      = '0;
            cand_d       = '0;
          end
        end
      end
    end

    // Match prefixes and run the three number scanners
    if (feed) begin
      if (pos_q < PW'(7) && data_byte_i != ver_char(pos_q[2:0])) begin
        ver_match_d = 1'b0;
      end
      if (pos_q < PW'(15) && lower != name_char(pos_q[3:0])) begin
        name_match_d = 1'b0;
      end
      mode9_d = scan_next(mode9_q, act9, is_digit, is_blank);
      mode5_d = scan_next(mode5_q, act5, is_digit, is_blank);
      model_d = scan_next(model_q, actl, is_digit, is_blank);
      if (mode9_d == SCAN_DIGITS && act9) begin
        code9_d = acc16(code9_q, digit);
      end
      if (mode5_d == SCAN_DIGITS && act5) begin
        code5_d = acc16(code5_q, digit);
      end
      if (model_d == SCAN_DIGITS && actl) begin
        cand_d = acc31(cand_q, digit);
      end
      pos_d = pos_q + PW'(1);
    end

    // Rearm after a result
    if (emit) begin
      phase_d      = PH_HEADER;
      pos_d        = '0;
      first_d      = 1'b1;
      ver_match_d  = 1'b1;
      name_match_d = 1'b1;
      mode9_d      = SCAN_SKIP;
      mode5_d      = SCAN_SKIP;
      model_d      = SCAN_SKIP;
      code9_d      = '0;
      code5_d      = '0;
      cand_d       = '0;
      status_d     = '0;
      len_seen_d   = 1'b0;
      len_d        = '0;
      hdr_seen_d   = '0;
      body_left_d  = '0;
    end
  end

  // Build the result word
  assign res_valid_o       = emit;
  assign res_o.status_code = status_q;
  assign res_o.body_length = emit_dead ? -32'sd1 : $signed({1'b0, emit_len});
  assign res_o.dead        = emit_dead;

  // Hold the parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      pos_q        <= '0;
      first_q      <= 1'b1;
      ver_match_q  <= 1'b1;
      name_match_q <= 1'b1;
      mode9_q      <= SCAN_SKIP;
      mode5_q      <= SCAN_SKIP;
      model_q      <= SCAN_SKIP;
      code9_q      <= '0;
      code5_q      <= '0;
      cand_q       <= '0;
      status_q     <= '0;
      len_seen_q   <= 1'b0;
      len_q        <= '0;
      hdr_seen_q   <= '0;
      body_left_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      first_q      <= first_d;
      ver_match_q  <= ver_match_d;
      name_match_q <= name_match_d;
      mode9_q      <= mode9_d;
      mode5_q      <= mode5_d;
      model_q      <= model_d;
      code9_q      <= code9_d;
      code5_q      <= code5_d;
      cand_q       <= cand_d;
      status_q     <= status_d;
      len_seen_q   <= len_seen_d;
      len_q        <= len_d;
      hdr_seen_q   <= hdr_seen_d;
      body_left_q  <= body_left_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/hrhp_result_reg.sv */
// ----------------------------------------------------------------------------
// hrhp_result_reg
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_result_reg import hrhp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire hrhp_result_t push_data_i,
  output      logic         room_o,
  hrhp_out_if.source        out_o
);

  logic         valid_q, valid_d;
  hrhp_result_t data_q;

  // Free when empty or when the held word leaves this cycle
  assign room_o = !valid_q || out_o.ready;

  // Drop on handshake, load on push
  always_comb begin
    valid_d = valid_q;
    if (valid_q && out_o.ready) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.status_code = data_q.status_code;
  assign out_o.body_length = data_q.body_length;
  assign out_o.dead        = data_q.dead;

endmodule

`default_nettype wire

/* rtl/http_response_header_parser_core.sv */
// Path: an accepted word waits in the input register until the output register has
//   room; the parser step then loads any result into the output register.
// Throughput: one byte per cycle; the parser step after the input register sets this
//   figure, and a full output register that the sink does not read stalls it.
// Reset: rst_ni clears all parser state and the input and output valid flags at once
//   and loads the header byte limit with 16384; no clearing pass is needed.
// ----------------------------------------------------------------------------
// http_response_header_parser_core
// HTTP/1.x response header parser with body drain and APB limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser_core import hrhp_pkg::*; #(
  parameter int unsigned LINE_BUF_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  hrhp_in_if.sink          in_i,
  hrhp_out_if.source       out_o
);

  logic         in_valid_q, in_valid_d;
  logic         action_q;
  logic [7:0]   byte_q;
  logic         accept, consume, room;
  logic [15:0]  limit_q;
  logic         cfg_write;
  logic         res_valid;
  hrhp_result_t res;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_IDX_LIMIT);
  assign prdata    = (paddr[2] == REG_IDX_LIMIT) ? {16'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit_q <= pwdata[15:0];
    end
  end

  // Input register: take a word whenever it is empty or the held one moves on
  assign consume    = in_valid_q && room;
  assign in_i.ready = !in_valid_q || room;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (consume) begin
      in_valid_d = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_i.action;
      byte_q   <= in_i.data_byte;
    end
  end

  hrhp_parser #(
    .LINE_BUF_BYTES (LINE_BUF_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (consume),
    .action_i     (action_q),
    .data_byte_i  (byte_q),
    .limit_i      (limit_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  hrhp_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (room),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* rtl/hrhp_checker.sv */
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks on the result channel of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] status_code,
  input wire logic [31:0] body_length,
  input wire logic        dead
);

  // Hold a stalled result word
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(status_code) && $stable(body_length) && $stable(dead))
    else $error("result word changed while stalled");

  // A dead response carries no length
  a_dead_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && dead |-> body_length == 32'hFFFF_FFFF)
    else $error("dead result with a body length");

  // A live response carries a length that fits 31 bits
  a_live_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !dead |-> !body_length[31])
    else $error("live result with a negative body length");

endmodule

bind http_response_header_parser_core hrhp_checker u_hrhp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .status_code (out_o.status_code),
  .body_length (out_o.body_length),
  .dead        (out_o.dead)
);

`default_nettype wire

/* tb/http_response_header_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// http_response_header_parser_core_tb
// Self-checking bench for the HTTP response header parser. A scoreboard
// class tracks the parser state in parallel with the block and queues a
// response summary when an accepted word closes one. Stimulus is a short directed
// opening, then randomised responses under several header byte limits. The
// randomised responses mix status lines, content-length lines, stray
// headers, long lines, bodies and stream closes with some noise. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser_core_tb;
  import hrhp_pkg::*;

  localparam int unsigned LINE_BUF_BYTES = 256;
  localparam int unsigned WAIT_MAX       = 18;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_MAX     = 10;
  localparam int unsigned NUM_PHASES     = 6;
  localparam logic [2:0]  LIMIT_ADDR     = {REG_IDX_LIMIT, 2'b00};
  localparam string       VERSION_TEXT   = "HTTP/1.";
  localparam string       NAME_TEXT      = "content-length:";

  // --------------------------------------------------------------------------
  // Scoreboard: parser state tracker and queue of pending response summaries
  // --------------------------------------------------------------------------
  class response_tracker;
    hrhp_result_t expected_responses[$];
    int unsigned  failures;
    logic [15:0]  limit;
    phase_e       phase;
    logic [7:0]   line_pos;
    bit           first_line;
    bit           version_ok;
    bit           name_ok;
    scan_e        scan_mode[3];
    logic [15:0]  code_col9;
    logic [15:0]  code_col5;
    logic [30:0]  length_cand;
    logic [15:0]  status;
    bit           length_seen;
    logic [30:0]  length_val;
    logic [16:0]  header_count;
    logic [30:0]  body_left;

    function new();
      failures = 0;
      limit    = LIMIT_RESET;
      restart();
    endfunction

    function void set_limit(logic [15:0] value);
      limit = value;
    endfunction

    function int unsigned pending_count();
      return expected_responses.size();
    endfunction

    function bit in_body();
      return phase == PH_BODY;
    endfunction

    function int unsigned body_left_count();
      return int'(body_left);
    endfunction

    function void clear_line();
      line_pos    = 8'd0;
      version_ok  = 1'b1;
      name_ok     = 1'b1;
      scan_mode   = '{SCAN_SKIP, SCAN_SKIP, SCAN_SKIP};
      code_col9   = 16'd0;
      code_col5   = 16'd0;
      length_cand = 31'd0;
    endfunction

    function void restart();
      phase        = PH_HEADER;
      first_line   = 1'b1;
      status       = 16'd0;
      length_seen  = 1'b0;
      length_val   = 31'd0;
      header_count = 17'd0;
      body_left    = 31'd0;
      clear_line();
    endfunction

    // Queue one summary and rearm for the next response
    function void close_response(bit is_dead);
      hrhp_result_t r;
      r.status_code = status;
      r.body_length = is_dead ? 32'hFFFF_FFFF : {1'b0, length_val};
      r.dead        = is_dead;
      expected_responses.push_back(r);
      restart();
    endfunction

    // Decimal accumulate with saturation at cap
    function logic [30:0] add_digit(logic [30:0] v, logic [7:0] ch, logic [30:0] cap);
      logic [63:0] n;
      n = 64'(v) * 64'd10 + 64'(ch - "0");
      return (n > 64'(cap)) ? cap : n[30:0];
    endfunction

    // Examine one stored character of the current line
    function void feed_char(logic [7:0] ch);
      logic [7:0]  lower;
      bit          digit;
      bit          blank;
      int unsigned cols[3];
      cols  = '{COL_CODE9, COL_CODE5, COL_LENGTH};
      lower = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      digit = ch >= "0" && ch <= "9";
      blank = ch == CHAR_SP || ch == CHAR_TAB;
      if (line_pos < 7 && ch != VERSION_TEXT[line_pos]) version_ok = 1'b0;
      if (line_pos < 15 && lower != NAME_TEXT[line_pos]) name_ok = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (line_pos >= cols[k] && scan_mode[k] != SCAN_DONE &&
            !(scan_mode[k] == SCAN_SKIP && blank)) begin
          if (!digit) begin
            scan_mode[k] = SCAN_DONE;
          end else begin
            scan_mode[k] = SCAN_DIGITS;
            case (k)
              0: code_col9 = 16'(add_digit({15'd0, code_col9}, ch, {15'd0, STATUS_MAX}));
              1: code_col5 = 16'(add_digit({15'd0, code_col5}, ch, {15'd0, STATUS_MAX}));
              default: length_cand = add_digit(length_cand, ch, LENGTH_MAX);
            endcase
          end
        end
      end
      line_pos = line_pos + 8'd1;
    endfunction

    // Advance the tracked parser by one accepted word
    function void parse_word(logic act, logic [7:0] ch);
      if (act) begin
        close_response(1'b1);
        return;
      end
      if (phase == PH_BODY) begin
        if (body_left != 0) body_left = body_left - 31'd1;
        if (body_left == 0) close_response(1'b0);
        return;
      end
      header_count = header_count + 17'd1;
      if (header_count > {1'b0, limit}) begin
        close_response(1'b1);
        return;
      end
      if (ch == CHAR_CR) return;
      if (ch != CHAR_LF) begin
        if (line_pos < LINE_BUF_BYTES - 1) feed_char(ch);
        return;
      end
      // End of line: blank line closes the headers
      if (line_pos == 0) begin
        if (first_line || !length_seen) begin
          close_response(1'b1);
        end else if (length_val == 0) begin
          close_response(1'b0);
        end else begin
          phase     = PH_BODY;
          body_left = length_val;
        end
        return;
      end
      if (first_line) begin
        first_line = 1'b0;
        if (line_pos >= 9 && version_ok) status = code_col9;
        else if (line_pos >= 6) status = code_col5;
      end else if (line_pos >= 15 && name_ok) begin
        length_val  = length_cand;
        length_seen = 1'b1;
      end
      clear_line();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("ERROR: %s", msg);
    endfunction

    // Compare one accepted result word with the oldest summary
    function void check_response(logic [15:0] code, logic [31:0] len, logic is_dead);
      hrhp_result_t r;
      if (expected_responses.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d length %0d dead %0b",
                               code, $signed(len), is_dead));
        return;
      end
      r = expected_responses.pop_front();
      if (code !== r.status_code || len !== r.body_length || is_dead !== r.dead)
        note_failure($sformatf("expected status %0d length %0d dead %0b, got %0d %0d %0b",
                               r.status_code, $signed(r.body_length), r.dead,
                               code, $signed(len), is_dead));
    endfunction

    function void check_drained();
      hrhp_result_t r;
      while (expected_responses.size() != 0) begin
        r = expected_responses.pop_front();
        note_failure($sformatf("missing result: status %0d length %0d dead %0b",
                               r.status_code, $signed(r.body_length), r.dead));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, ports
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hrhp_in_if  resp_in ();
  hrhp_out_if resp_out ();

  response_tracker tracker;
  int unsigned     words_sent  = 0;
  int unsigned     idle_cycles = 0;
  int              tx_burst    = 0;
  int              rx_burst    = 0;

  always #5 clk_i = ~clk_i;

  http_response_header_parser_core #(
    .LINE_BUF_BYTES(LINE_BUF_BYTES)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_i  (resp_in),
    .out_o (resp_out)
  );

  // Wait length per word: zero in bursts, otherwise half zero, half 0..18
  function automatic int unsigned draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) burst = $urandom_range(20, 80);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_word(logic act, logic [7:0] b);
    int unsigned gap;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      resp_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    resp_in.valid     <= 1'b1;
    resp_in.action    <= act;
    resp_in.data_byte <= b;
    do @(posedge clk_i); while (resp_in.ready !== 1'b1);
    tracker.parse_word(act, b);
    words_sent++;
  endtask

  // Drop valid and hold until every pending summary has come out
  task automatic hold_off();
    resp_in.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_limit(value);
  endtask

  task automatic change_limit(logic [15:0] value);
    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_limit(value);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic send_eol();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 5) send_word(1'b0, CHAR_CR);
    if (r < 3 || r == 5) send_word(1'b0, CHAR_CR);
    send_word(1'b0, CHAR_LF);
  endtask

  task automatic send_blanks(int unsigned n);
    repeat (n) send_word(1'b0, ($urandom_range(0, 1) == 0) ? CHAR_SP : CHAR_TAB);
  endtask

  task automatic send_digits(int unsigned n);
    repeat (n) send_word(1'b0, 8'("0" + $urandom_range(0, 9)));
  endtask

  // Random bytes that never end the line
  task automatic send_junk(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF) b = 8'h00;
      send_word(1'b0, b);
    end
  endtask

  task automatic send_status_code();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) send_digits(3);
    else if (r == 7) send_digits($urandom_range(1, 2));
    else if (r == 8) send_digits($urandom_range(5, 8));
    else send_text("x");
  endtask

  task automatic send_status_line();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      send_text(VERSION_TEXT);
      send_digits(1);
      send_blanks(($urandom_range(0, 3) == 0) ? 2 : 1);
      send_status_code();
      if ($urandom_range(0, 1) == 0) send_text(" OK");
      else send_junk($urandom_range(0, 8));
    end else if (r == 6) begin
      // Version only: too short for column 9
      send_text(VERSION_TEXT);
      send_digits(1);
    end else if (r == 7) begin
      send_text("http/1.");
      send_digits(1);
      send_blanks(1);
      send_status_code();
    end else if (r == 8) begin
      send_junk($urandom_range(0, 12));
    end else begin
      send_junk(4);
      send_blanks($urandom_range(0, 2));
      send_status_code();
    end
  endtask

  task automatic send_length_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) begin
      if ($urandom_range(0, 4) == 0) send_text("0");
      send_text($sformatf("%0d", $urandom_range(0, 30)));
    end else if (r < 14) begin
      send_text($sformatf("%0d", $urandom_range(31, 300)));
    end else if (r < 16) begin
      send_digits($urandom_range(10, 12));
    end else if (r < 18) begin
      send_text("x7");
    end else if (r == 19) begin
      send_digits($urandom_range(0, 3));
    end
  endtask

  task automatic send_length_header();
    string name;
    name = NAME_TEXT;
    for (int i = 0; i < name.len(); i++)
      if (name[i] >= "a" && name[i] <= "z" && $urandom_range(0, 1) == 0)
        name[i] = name[i] - 8'd32;
    // Near miss on the field name now and then
    if ($urandom_range(0, 9) == 0) name[$urandom_range(0, 14)] = "_";
    send_text(name);
    if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 3));
    send_length_value();
    if ($urandom_range(0, 4) == 0) send_junk($urandom_range(1, 4));
  endtask

  task automatic send_header_line();
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r < 15) begin
      send_length_header();
    end else if (r == 15) begin
      // Past the stored part of the line
      send_text("Content-Length:");
      send_blanks($urandom_range(230, 250));
      send_digits($urandom_range(1, 20));
    end else if (r < 18) begin
      send_text(NAME_TEXT);
    end else if (r < 22) begin
      send_text("Content-Type: ");
      send_junk($urandom_range(0, 10));
    end else begin
      send_junk($urandom_range(0, 20));
    end
    send_eol();
  endtask

  task automatic send_response();
    int unsigned r;
    int unsigned left;
    if ($urandom_range(0, 24) == 0) hold_off();
    if ($urandom_range(0, 24) == 0) begin
      send_eol();
      return;
    end
    send_status_line();
    send_eol();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 2))
      send_header_line();
    r = $urandom_range(0, 19);
    // Close inside the headers, or run straight into the next response
    if (r == 0) begin
      send_word(1'b1, 8'($urandom_range(0, 255)));
      return;
    end
    if (r == 1) return;
    send_eol();
    if (tracker.in_body()) begin
      left = tracker.body_left_count();
      if (left <= 300 && $urandom_range(0, 7) != 0) begin
        repeat (left) send_word(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, (left > 20) ? 20 : left - 1))
          send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 16))
      send_word($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(int unsigned count);
    int unsigned target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_response();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] limits[NUM_PHASES];
    int unsigned counts[NUM_PHASES];
    tracker = new();
    limits = '{16'hFFFF, 16'd1, 16'($urandom_range(16, 120)), LIMIT_RESET,
               16'($urandom_range(1, 65535)), 16'($urandom_range(121, 600))};
    counts = '{430, 100, 350, 350, 300, 320};
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= 3'd0;
    pwdata            <= 32'd0;
    resp_in.valid     <= 1'b0;
    resp_in.action    <= 1'b0;
    resp_in.data_byte <= 8'h00;
    resp_out.ready    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Blank first line, stream close, CR dropped before a blank first line
    send_word(1'b0, CHAR_LF);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, CHAR_CR);
    send_word(1'b0, CHAR_LF);
    // Status from column 5, headers end without a length
    send_text("ABCDE7");
    send_word(1'b0, CHAR_LF);
    send_word(1'b0, CHAR_LF);
    // Extreme bytes, then close mid-line
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'h00);
    hold_off();

    for (int i = 0; i < NUM_PHASES; i++) begin
      change_limit(limits[i]);
      run_phase(counts[i]);
    end

    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    tracker.check_drained();
    if (tracker.failures == 0) begin
      $display("http_response_header_parser_core: match");
    end else begin
      $display("http_response_header_parser_core: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, check each accepted word
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(rx_burst);
      if (stall > 0) begin
        resp_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      resp_out.ready <= 1'b1;
      do @(posedge clk_i); while (!(resp_out.valid === 1'b1 && resp_out.ready === 1'b1));
      tracker.check_response(resp_out.status_code, resp_out.body_length, resp_out.dead);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no word moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((resp_in.valid === 1'b1 && resp_in.ready === 1'b1) ||
        (resp_out.valid === 1'b1 && resp_out.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("http_response_header_parser_core: mismatch");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/hrhp_pkg.sv
rtl/hrhp_in_if.sv
rtl/hrhp_out_if.sv
rtl/hrhp_parser.sv
rtl/hrhp_result_reg.sv
rtl/http_response_header_parser_core.sv
rtl/hrhp_checker.sv
tb/http_response_header_parser_core_tb.sv
